FILE: rtl/dtli_pkg.sv
// Shared constants and types of the dual table linear interpolator.
`default_nettype none

package dtli_pkg;

    localparam int SAMPLE_W      = 32;
    localparam int ADDR_W        = 15;
    localparam int POS_FRAC_BITS = 40;
    localparam int IDX_BITS      = 24;
    localparam int ITEM_DATA_W   = 2 * SAMPLE_W;
    localparam int KIND_W        = 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = 2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVAL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAULT = 2'd2;

    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_INV_STEP    = 1'b1;

    localparam logic [15:0]         POINT_COUNT_RESET = 16'd20001;
    localparam logic [31:0]         INV_STEP_RESET    = 32'd65536000;
    localparam logic [SAMPLE_W-1:0] SIGN_FLIP         = 32'h8000_0000;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

FILE: rtl/dtli_queue.sv
// Small request queue between the front and back parts.
`default_nettype none

module dtli_queue
    import dtli_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_item,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head_item,
    output queue_status_t         status
);

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

FILE: rtl/dtli_front.sv
// Front part: takes requests, forms the table position and classifies them.
`default_nettype none

module dtli_front
    import dtli_pkg::*;
#(
    parameter int TABLE_DEPTH   = 32768,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_action,
    input  wire logic [ADDR_W-1:0]   s_addr,
    input  wire logic [SAMPLE_W-1:0] s_first,
    input  wire logic [SAMPLE_W-1:0] s_second,
    input  wire logic [SAMPLE_W-1:0] s_pos,
    input  wire logic [15:0]         point_count,
    input  wire logic [31:0]         inv_step,
    input  queue_status_t            q_status,
    output logic                     push,
    output logic [KIND_W+FRACTION_BITS+$clog2(TABLE_DEPTH+1)+ITEM_DATA_W-1:0] push_item
);

    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_BITS-1:0] DEPTH_IDX = IDX_BITS'(TABLE_DEPTH);

    logic                   valid_reg;
    logic                   action_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [ITEM_DATA_W-1:0] data_reg;
    logic                   neg_reg;
    logic [63:0]            prod_reg;
    logic [63:0]            prod_next;

    logic [IDX_BITS-1:0]      pc_idx;
    logic [IDX_BITS-1:0]      cnt;
    logic [IDX_BITS-1:0]      cnt_m1;
    logic [IDX_BITS-1:0]      idx;
    logic                     rem_nz;
    logic                     bad;
    logic                     last_seg;
    logic                     drop;
    logic [KIND_W-1:0]        kind;
    logic [IW-1:0]            index;
    logic [FRACTION_BITS-1:0] frac;

    assign prod_next = 64'(s_pos) * 64'(inv_step);

    assign s_ready = !valid_reg || drop || !q_status.full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            addr_reg   <= s_addr;
            data_reg   <= {s_second, s_first};
            neg_reg    <= s_pos[SAMPLE_W-1];
            prod_reg   <= prod_next;
        end
    end

    // Clamp the count to the table size, treat zero as one.
    always_comb begin
        pc_idx = IDX_BITS'(point_count);
        priority if (pc_idx == '0) begin
            cnt = IDX_BITS'(1);
        end else if (pc_idx > DEPTH_IDX) begin
            cnt = DEPTH_IDX;
        end else begin
            cnt = pc_idx;
        end
    end

    assign cnt_m1   = cnt - IDX_BITS'(1);
    assign idx      = prod_reg[63:POS_FRAC_BITS];
    assign rem_nz   = |prod_reg[POS_FRAC_BITS-1:0];
    assign bad      = neg_reg || (idx > cnt) || ((idx == cnt) && rem_nz);
    assign last_seg = (idx >= cnt_m1);

    always_comb begin
        drop = 1'b0;
        kind = KIND_EVAL;
        index = '0;
        frac = '0;
        if (action_reg == ACT_WRITE) begin
            kind  = KIND_WRITE;
            index = IW'(addr_reg);
            drop  = (IDX_BITS'(addr_reg) >= DEPTH_IDX);
        end else if (bad) begin
            kind = KIND_FAULT;
        end else if (last_seg) begin
            // Last segment: weight zero on the next entry returns the entry itself.
            index = cnt_m1[IW-1:0];
        end else begin
            index = idx[IW-1:0];
            frac  = prod_reg[POS_FRAC_BITS-1 -: FRACTION_BITS];
        end
    end

    assign push      = valid_reg && !drop && !q_status.full;
    assign push_item = {kind, frac, index, data_reg};

endmodule

`default_nettype wire

FILE: rtl/dtli_back.sv
// Back part: table storage, paired entry reads and the two-column blend.
`default_nettype none

module dtli_back
    import dtli_pkg::*;
#(
    parameter int TABLE_DEPTH   = 32768,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  queue_status_t            q_status,
    input  wire logic [KIND_W+FRACTION_BITS+$clog2(TABLE_DEPTH+1)+ITEM_DATA_W-1:0] q_item,
    output logic                     pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [SAMPLE_W-1:0]      m_first,
    output logic [SAMPLE_W-1:0]      m_second,
    output logic                     m_fault
);

    localparam int IW   = $clog2(TABLE_DEPTH + 1);
    localparam int ROWS = TABLE_DEPTH / 2 + 1;
    localparam int RW   = $clog2(ROWS);
    localparam int PW   = SAMPLE_W + FRACTION_BITS + 1;
    localparam logic [FRACTION_BITS:0] WEIGHT_ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
    localparam logic [PW-1:0] HALF_LSB = PW'(1) << (FRACTION_BITS - 1);

    logic [ITEM_DATA_W-1:0]   q_data;
    logic [IW-1:0]            q_index;
    logic [FRACTION_BITS-1:0] q_frac;
    logic [KIND_W-1:0]        q_kind;
    logic                     is_write;
    logic                     wr_en;
    logic                     rd_en;
    logic [RW-1:0]            half_row;
    logic [RW-1:0]            even_row;

    logic [ITEM_DATA_W-1:0] even_mem [ROWS];
    logic [ITEM_DATA_W-1:0] odd_mem  [ROWS];
    logic [ITEM_DATA_W-1:0] even_rd_reg;
    logic [ITEM_DATA_W-1:0] odd_rd_reg;

    logic                     b1_valid_reg;
    logic                     b1_fault_reg;
    logic                     b1_odd_reg;
    logic [FRACTION_BITS-1:0] b1_frac_reg;

    logic                     b2_valid_reg;
    logic                     b2_fault_reg;
    logic [PW-1:0]            pa1_reg;
    logic [PW-1:0]            pb1_reg;
    logic [PW-1:0]            pa2_reg;
    logic [PW-1:0]            pb2_reg;

    logic                     m_valid_reg;
    logic [SAMPLE_W-1:0]      m_first_reg;
    logic [SAMPLE_W-1:0]      m_second_reg;
    logic                     m_fault_reg;

    logic out_ready;
    logic b2_ready;
    logic b1_ready;

    logic [ITEM_DATA_W-1:0]   ent_a;
    logic [ITEM_DATA_W-1:0]   ent_b;
    logic [FRACTION_BITS:0]   w_a;
    logic [FRACTION_BITS:0]   w_b;
    logic [PW-1:0]            sum1;
    logic [PW-1:0]            sum2;
    logic [SAMPLE_W:0]        r1;
    logic [SAMPLE_W:0]        r2;
    logic [SAMPLE_W-1:0]      y1;
    logic [SAMPLE_W-1:0]      y2;

    assign q_data  = q_item[ITEM_DATA_W-1:0];
    assign q_index = q_item[ITEM_DATA_W +: IW];
    assign q_frac  = q_item[ITEM_DATA_W+IW +: FRACTION_BITS];
    assign q_kind  = q_item[ITEM_DATA_W+IW+FRACTION_BITS +: KIND_W];

    assign is_write = (q_kind == KIND_WRITE);
    assign pop      = !q_status.empty && (is_write || b1_ready);
    assign wr_en    = pop && is_write;
    assign rd_en    = pop && !is_write;

    // Even entries live in one bank, odd in the other: idx and idx+1 never share a bank.
    assign half_row = RW'(q_index[IW-1:1]);
    assign even_row = q_index[0] ? half_row + RW'(1) : half_row;

    always_ff @(posedge aclk) begin
        if (wr_en && !q_index[0]) begin
            even_mem[half_row] <= q_data;
        end
        if (wr_en && q_index[0]) begin
            odd_mem[half_row] <= q_data;
        end
        if (rd_en) begin
            even_rd_reg <= even_mem[even_row];
            odd_rd_reg  <= odd_mem[half_row];
        end
    end

    assign out_ready = !m_valid_reg || m_ready;
    assign b2_ready  = !b2_valid_reg || out_ready;
    assign b1_ready  = !b1_valid_reg || b2_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (b1_ready) begin
                b1_valid_reg <= rd_en;
            end
            if (b2_ready) begin
                b2_valid_reg <= b1_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= b2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            b1_fault_reg <= (q_kind == KIND_FAULT);
            b1_odd_reg   <= q_index[0];
            b1_frac_reg  <= q_frac;
        end
    end

    // Offset binary keeps the blend unsigned; weights sum to one.
    // Zero weight: reuse the lower entry so the unused neighbor never enters the sum.
    assign ent_a = b1_odd_reg ? odd_rd_reg : even_rd_reg;
    assign ent_b = (b1_frac_reg == '0) ? ent_a : (b1_odd_reg ? even_rd_reg : odd_rd_reg);
    assign w_b   = (FRACTION_BITS + 1)'(b1_frac_reg);
    assign w_a   = WEIGHT_ONE - w_b;

    always_ff @(posedge aclk) begin
        if (b2_ready && b1_valid_reg) begin
            b2_fault_reg <= b1_fault_reg;
            pa1_reg <= PW'(ent_a[SAMPLE_W-1:0] ^ SIGN_FLIP) * PW'(w_a);
            pb1_reg <= PW'(ent_b[SAMPLE_W-1:0] ^ SIGN_FLIP) * PW'(w_b);
            pa2_reg <= PW'(ent_a[ITEM_DATA_W-1:SAMPLE_W] ^ SIGN_FLIP) * PW'(w_a);
            pb2_reg <= PW'(ent_b[ITEM_DATA_W-1:SAMPLE_W] ^ SIGN_FLIP) * PW'(w_b);
        end
    end

    assign sum1 = pa1_reg + pb1_reg + HALF_LSB;
    assign sum2 = pa2_reg + pb2_reg + HALF_LSB;
    assign r1   = sum1[PW-1:FRACTION_BITS];
    assign r2   = sum2[PW-1:FRACTION_BITS];
    assign y1   = (r1[SAMPLE_W] ? '1 : r1[SAMPLE_W-1:0]) ^ SIGN_FLIP;
    assign y2   = (r2[SAMPLE_W] ? '1 : r2[SAMPLE_W-1:0]) ^ SIGN_FLIP;

    always_ff @(posedge aclk) begin
        if (out_ready && b2_valid_reg) begin
            m_first_reg  <= b2_fault_reg ? '0 : y1;
            m_second_reg <= b2_fault_reg ? '0 : y2;
            m_fault_reg  <= b2_fault_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_first  = m_first_reg;
    assign m_second = m_second_reg;
    assign m_fault  = m_fault_reg;

endmodule

`default_nettype wire

FILE: rtl/dual_table_linear_interpolator_unit.sv
// Path: front register, queue, table read registers, product registers, output register.
// Throughput: one request per cycle, writes and evaluations alike, unless the result side
// stalls; the front multiply, the four-entry queue and the two-bank table read sustain it.
// Reset: clears pipeline valids and queue pointers, sets point_count to 20001 and
// inv_step to 65536000; table entries are undefined until written.
`default_nettype none

module dual_table_linear_interpolator_unit
    import dtli_pkg::*;
#(
    parameter int TABLE_DEPTH   = 32768,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [14:0] entry_address, [46:15] first_sample, [78:47] second_sample,
    // [110:79] position, [111] zero
    input  wire logic [111:0] s_tdata,
    // [0] action
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] first_value, [63:32] second_value
    output logic [63:0]       m_tdata,
    // [0] out_of_range
    output logic              m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IW     = $clog2(TABLE_DEPTH + 1);
    localparam int ITEM_W = KIND_W + FRACTION_BITS + IW + ITEM_DATA_W;

    logic [15:0]         point_count_reg;
    logic [31:0]         inv_step_reg;
    logic                cfg_write;

    logic                push;
    logic                pop;
    logic [ITEM_W-1:0]   push_item;
    logic [ITEM_W-1:0]   head_item;
    queue_status_t       q_status;

    logic [SAMPLE_W-1:0] m_first;
    logic [SAMPLE_W-1:0] m_second;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= POINT_COUNT_RESET;
            inv_step_reg    <= INV_STEP_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_POINT_COUNT: point_count_reg <= pwdata[15:0];
                REG_INV_STEP:    inv_step_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_POINT_COUNT: prdata = {16'b0, point_count_reg};
            REG_INV_STEP:    prdata = inv_step_reg;
            default:         prdata = '0;
        endcase
    end

    dtli_front #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_action   (s_tuser),
        .s_addr     (s_tdata[14:0]),
        .s_first    (s_tdata[46:15]),
        .s_second   (s_tdata[78:47]),
        .s_pos      (s_tdata[110:79]),
        .point_count(point_count_reg),
        .inv_step   (inv_step_reg),
        .q_status   (q_status),
        .push       (push),
        .push_item  (push_item)
    );

    dtli_queue #(
        .WIDTH(ITEM_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .head_item(head_item),
        .status   (q_status)
    );

    dtli_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_status(q_status),
        .q_item  (head_item),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_first (m_first),
        .m_second(m_second),
        .m_fault (m_tuser)
    );

    assign m_tdata = {m_second, m_first};

endmodule

`default_nettype wire

FILE: bench/tb_dual_table_linear_interpolator_unit.sv
// Self-checking bench for the dual table linear interpolator: table loads, evaluations, registers.
module tb_dual_table_linear_interpolator_unit;
    import dtli_pkg::*;

    localparam int          DEPTH        = 32768;
    localparam int          FRAC_BITS    = 16;
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned LIMIT_CYCLES = 600000;
    localparam int          ROUND_ITEMS  = 80;

    typedef struct packed {
        logic [SAMPLE_W-1:0] first_value;
        logic [SAMPLE_W-1:0] second_value;
        logic                out_of_range;
    } interp_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // [14:0] entry_address, [46:15] first_sample, [78:47] second_sample,
    // [110:79] position, [111] zero
    logic [111:0] s_tdata;
    // [0] action
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // [31:0] first_value, [63:32] second_value
    logic [63:0]  m_tdata;
    // [0] out_of_range
    logic         m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow copy of the table and registers
    logic [SAMPLE_W-1:0] first_col  [DEPTH];
    logic [SAMPLE_W-1:0] second_col [DEPTH];
    bit                  entry_loaded [DEPTH];
    logic [15:0]         cfg_point_count;
    logic [31:0]         cfg_inv_step;

    interp_result_t pending_results[$];

    bit          src_gaps_on;
    bit          sink_gaps_on;
    int unsigned sink_hold_cycles;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned table_writes;
    int unsigned evaluations;
    int unsigned out_of_range_hits;
    int unsigned register_writes;

    dual_table_linear_interpolator_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("dual_table_linear_interpolator_unit verification failed");
            $finish;
        end
    end

    // Count clamped to the range the table can hold.
    function automatic int unsigned active_count();
        int unsigned cnt;
        cnt = cfg_point_count;
        if (cnt == 0)
            cnt = 1;
        if (cnt > DEPTH)
            cnt = DEPTH;
        return cnt;
    endfunction

    // Returns 1 when the position lies outside the table; otherwise the two entries and weight.
    function automatic logic locate(input logic [31:0] pos, output int unsigned lo_entry,
                                    output int unsigned hi_entry,
                                    output logic [FRAC_BITS-1:0] weight);
        int unsigned cnt;
        logic [63:0] prod;
        logic [63:0] idx;
        cnt = active_count();
        lo_entry = 0;
        hi_entry = 0;
        weight = '0;
        if (pos[31])
            return 1'b1;
        prod = {32'b0, pos} * {32'b0, cfg_inv_step};
        idx = prod >> POS_FRAC_BITS;
        if (idx > cnt || (idx == cnt && prod[POS_FRAC_BITS-1:0] != '0))
            return 1'b1;
        if (idx + 1 < cnt) begin
            lo_entry = 32'(idx);
            hi_entry = 32'(idx + 64'd1);
            weight = prod[POS_FRAC_BITS-1 -: FRAC_BITS];
        end else begin
            lo_entry = cnt - 1;
            hi_entry = cnt - 1;
        end
        return 1'b0;
    endfunction

    // Round to nearest in offset binary, ties upward, then saturate.
    function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                          input logic [FRAC_BITS-1:0] weight);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] scale;
        logic [63:0] total;
        ua = {32'b0, a ^ SIGN_FLIP};
        ub = {32'b0, b ^ SIGN_FLIP};
        scale = 64'd1 << FRAC_BITS;
        total = ua * (scale - weight) + ub * weight + (scale >> 1);
        total = total >> FRAC_BITS;
        if (total > 64'hFFFF_FFFF)
            total = 64'hFFFF_FFFF;
        return total[31:0] ^ SIGN_FLIP;
    endfunction

    function automatic interp_result_t interpolate(input logic [31:0] pos);
        interp_result_t res;
        int unsigned lo;
        int unsigned hi;
        logic [FRAC_BITS-1:0] weight;
        res = '0;
        res.out_of_range = locate(pos, lo, hi, weight);
        if (!res.out_of_range) begin
            res.first_value  = blend(first_col[lo], first_col[hi], weight);
            res.second_value = blend(second_col[lo], second_col[hi], weight);
        end
        return res;
    endfunction

    // Mostly positions aimed inside the table, some raw and negative ones.
    function automatic logic [31:0] pick_position();
        int unsigned roll;
        int unsigned cnt;
        int unsigned idx;
        logic [39:0] frac;
        logic [63:0] target;
        logic [63:0] x;
        roll = $urandom_range(0, 99);
        cnt = active_count();
        if (roll < 12)
            return $urandom;
        if (roll < 20)
            return {1'b1, 31'($urandom)};
        case ($urandom_range(0, 2))
            0: idx = $urandom_range(0, cnt);
            1: idx = $urandom_range(0, (cnt < 40) ? cnt : 40);
            default: idx = (cnt < 3) ? $urandom_range(0, cnt) : $urandom_range(cnt - 3, cnt);
        endcase
        frac = (roll < 30) ? '0 : {8'($urandom), 32'($urandom)};
        target = (64'(idx) << POS_FRAC_BITS) | 64'(frac);
        if (cfg_inv_step == 0)
            x = 64'($urandom & 32'h7FFF_FFFF);
        else
            x = target / cfg_inv_step + ((roll % 3 == 0) ? 1 : 0);
        if (x > 64'h7FFF_FFFF)
            x = 64'h7FFF_FFFF;
        return x[31:0];
    endfunction

    task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr,
                             input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] pos);
        int unsigned gap;
        gap = src_gaps_on ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, pos, b, a, addr};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (act == ACT_WRITE) begin
            first_col[addr]    = a;
            second_col[addr]   = b;
            entry_loaded[addr] = 1'b1;
            table_writes++;
        end else begin
            pending_results.push_back(interpolate(pos));
            evaluations++;
            if (pending_results[$].out_of_range)
                out_of_range_hits++;
        end
    endtask

    task automatic load_entry(input int unsigned addr, input logic [31:0] a,
                              input logic [31:0] b);
        send_item(ACT_WRITE, ADDR_W'(addr), a, b, $urandom);
    endtask

    // Load whatever entries the evaluation reads, then request it.
    task automatic evaluate(input logic [31:0] pos);
        int unsigned lo;
        int unsigned hi;
        logic [FRAC_BITS-1:0] weight;
        if (!locate(pos, lo, hi, weight)) begin
            if (!entry_loaded[lo])
                load_entry(lo, $urandom, $urandom);
            if (!entry_loaded[hi])
                load_entry(hi, $urandom, $urandom);
        end
        send_item(ACT_EVAL, ADDR_W'($urandom), $urandom, $urandom, pos);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_read_check(input logic idx);
        logic [31:0] want;
        want = (idx == REG_POINT_COUNT) ? {16'b0, cfg_point_count} : cfg_inv_step;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $error("register %0d: expected %h, got %h", idx, want, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_POINT_COUNT)
            cfg_point_count = value[15:0];
        else
            cfg_inv_step = value;
        register_writes++;
        @(posedge aclk);
        reg_read_check(idx);
    endtask

    // Result sink: per-result stall, plus a long hold-off when requested.
    initial begin : result_sink
        int unsigned pause;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (sink_hold_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge aclk);
                sink_hold_cycles = 0;
            end else begin
                pause = sink_gaps_on ? $urandom_range(0, 16) : 0;
                if (pause != 0) begin
                    m_tready <= 1'b0;
                    repeat (pause) @(posedge aclk);
                end
                m_tready <= 1'b1;
                do @(posedge aclk); while (!(m_tvalid && m_tready) && sink_hold_cycles == 0);
            end
        end
    end

    always @(posedge aclk) begin
        interp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no evaluation outstanding: %h / %b", m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.first_value) begin
                    $error("first_value: expected %h, got %h", want.first_value, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[63:32] !== want.second_value) begin
                    $error("second_value: expected %h, got %h", want.second_value,
                           m_tdata[63:32]);
                    mismatch_count++;
                end
                if (m_tuser !== want.out_of_range) begin
                    $error("out_of_range: expected %b, got %b", want.out_of_range, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Reset values, then a few lookups against the reset spacing of 1/1000.
    task automatic test_reset_state();
        reg_read_check(REG_POINT_COUNT);
        reg_read_check(REG_INV_STEP);
        evaluate(32'h0000_0000);
        evaluate(32'h0100_0000);
        evaluate(32'h1400_0000);
        evaluate(32'h147A_E147);
        evaluate(32'h8000_0000);
        evaluate(32'hFFFF_FFFF);
        evaluate(32'h7FFF_FFFF);
        drain();
    endtask

    task automatic test_edge_cases();
        reg_write(REG_POINT_COUNT, 32'd5);
        reg_write(REG_INV_STEP, 32'h0001_0000);
        load_entry(0, 32'h7FFF_FFFF, 32'h8000_0000);
        load_entry(1, 32'h8000_0000, 32'h7FFF_FFFF);
        evaluate(32'h0080_0000);
        evaluate(32'h00FF_FFFF);
        evaluate(32'h0380_0000);
        // last segment, exact table end, just past the end
        evaluate(32'h0412_3456);
        evaluate(32'h0500_0000);
        evaluate(32'h0500_0001);
        drain();
        // zero spacing reciprocal pins every position to entry zero
        reg_write(REG_INV_STEP, 32'h0000_0000);
        evaluate(32'h1234_5678);
        drain();
        // a zero count behaves as one entry
        reg_write(REG_POINT_COUNT, 32'd0);
        evaluate(32'h0000_0000);
        drain();
        reg_write(REG_INV_STEP, 32'h0001_0000);
        evaluate(32'h0100_0000);
        evaluate(32'h0100_0001);
        drain();
        // counts above the table size clamp to it
        reg_write(REG_POINT_COUNT, 32'd65535);
        reg_write(REG_INV_STEP, 32'h0200_0000);
        evaluate(32'h3FFF_4000);
        evaluate(32'h3FFF_8000);
        evaluate(32'h4000_0000);
        evaluate(32'h4000_0001);
        drain();
        reg_write(REG_POINT_COUNT, 32'd32768);
        evaluate(32'h4000_0000);
        evaluate(32'h3FFF_C000);
        drain();
    endtask

    task automatic test_random_traffic();
        logic [15:0] counts [8];
        logic [31:0] steps  [8];
        int unsigned goal;
        counts = '{16'd20001, 16'd1, 16'd2, 16'd0, 16'd65535, 16'd32768, 16'd7, 16'd0};
        steps  = '{32'd65536000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0,
                   32'h0200_0000, 32'd1, 32'h0003_0000, 32'h0};
        counts[7] = 16'($urandom_range(1, 300));
        steps[7]  = $urandom_range(32'h0000_1000, 32'h0100_0000);
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(REG_POINT_COUNT, {16'b0, counts[ph]});
            reg_write(REG_INV_STEP, steps[ph]);
            src_gaps_on  = ph[0];
            sink_gaps_on = ph[1];
            goal = items_sent + ROUND_ITEMS;
            while (items_sent < goal) begin
                if ($urandom_range(0, 4) == 0)
                    load_entry(($urandom_range(0, 1) == 0) ? ($urandom & 32'h7FFF)
                                                          : $urandom_range(0, 40),
                               $urandom, $urandom);
                else
                    evaluate(pick_position());
            end
            drain();
        end
    endtask

    // Hold the result side off long enough for the input side to back up.
    task automatic test_backpressure();
        reg_write(REG_POINT_COUNT, 32'd48);
        reg_write(REG_INV_STEP, 32'h0001_0000);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        sink_hold_cycles = 300;
        repeat (40) evaluate(pick_position());
        drain();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= ACT_WRITE;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cycle_count      = 0;
        mismatch_count   = 0;
        items_sent       = 0;
        table_writes     = 0;
        evaluations      = 0;
        out_of_range_hits = 0;
        register_writes  = 0;
        sink_hold_cycles = 0;
        src_gaps_on      = 1'b1;
        sink_gaps_on     = 1'b1;
        cfg_point_count  = POINT_COUNT_RESET;
        cfg_inv_step     = INV_STEP_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_edge_cases();
        test_backpressure();
        test_random_traffic();
        drain();

        $display("Covered %0d table loads and %0d lookups (%0d outside the table)",
                 table_writes, evaluations, out_of_range_hits);
        $display("over %0d register writes, with random and held-off flow control.",
                 register_writes);
        if (mismatch_count == 0)
            $display("dual_table_linear_interpolator_unit verification clean");
        else
            $display("dual_table_linear_interpolator_unit verification failed");
        $finish;
    end

endmodule
